[rtl/core/mvol_pkg.sv]
// Package: shared widths, parse phase codes and parse state type of the VOL header parser.
`default_nettype none
package mvol_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DIM_W  = 13;
    localparam int unsigned BUF_W  = 24;
    localparam int unsigned LEFT_W = 5;
    localparam int unsigned RES_W  = 16;

    typedef enum logic [5:0] {
        PH_SCAN       = 6'd0,
        PH_VO_ID      = 6'd1,
        PH_VO_IDX     = 6'd2,
        PH_VO_TYPE    = 6'd3,
        PH_SIG        = 6'd4,
        PH_SIG_FMT    = 6'd5,
        PH_COLOR      = 6'd6,
        PH_COLOR_X    = 6'd7,
        PH_ALIGN      = 6'd8,
        PH_VO_PFX     = 6'd9,
        PH_VO_CODE    = 6'd10,
        PH_VOL_PFX    = 6'd11,
        PH_VOL_CODE   = 6'd12,
        PH_RAND       = 6'd13,
        PH_OTI        = 6'd14,
        PH_OLID       = 6'd15,
        PH_OLVER      = 6'd16,
        PH_OLPRI      = 6'd17,
        PH_ASPECT     = 6'd18,
        PH_PAR        = 6'd19,
        PH_CTRL       = 6'd20,
        PH_CHROMA     = 6'd21,
        PH_VBV        = 6'd22,
        PH_VBV_A      = 6'd23,
        PH_VBV_MK1    = 6'd24,
        PH_VBV_B      = 6'd25,
        PH_VBV_MK2    = 6'd26,
        PH_VBV_C      = 6'd27,
        PH_VBV_MK3    = 6'd28,
        PH_VBV_D      = 6'd29,
        PH_VBV_MK4    = 6'd30,
        PH_VBV_E      = 6'd31,
        PH_VBV_LASTMK = 6'd32,
        PH_SHAPE      = 6'd33,
        PH_SHAPE_X    = 6'd34,
        PH_MK_RES     = 6'd35,
        PH_RES        = 6'd36,
        PH_MK_RATE    = 6'd37,
        PH_FIXED      = 6'd38,
        PH_INC        = 6'd39,
        PH_MK_W       = 6'd40,
        PH_WIDTH      = 6'd41,
        PH_MK_H       = 6'd42,
        PH_HEIGHT     = 6'd43,
        PH_MK_END     = 6'd44,
        PH_VOP        = 6'd45
    } phase_t;

    localparam logic [23:0] START_PREFIX = 24'h000001;
    localparam logic [7:0]  CODE_VO      = 8'hb5;
    localparam logic [7:0]  CODE_VOP     = 8'hb6;
    localparam logic [7:0]  VO_CODE_MAX  = 8'h1f;
    localparam logic [7:0]  VOL_CODE_MIN = 8'h20;
    localparam logic [7:0]  VOL_CODE_MAX = 8'h2f;
    localparam logic [7:0]  OTI_BAD      = 8'h12;

    typedef struct packed {
        phase_t              phase;
        logic [23:0]         window;
        logic [BUF_W-1:0]    bits;
        logic [LEFT_W-1:0]   left;
        logic [3:0]          version;
        logic [1:0]          shape;
        logic [RES_W-1:0]    res;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic                key;
        logic                stopped;
    } parse_state_t;

endpackage
`default_nettype wire

[rtl/core/mvol_if.sv]
// Interfaces: byte input channel and size report channel.
`default_nettype none
interface mvol_byte_if
    import mvol_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mvol_report_if
    import mvol_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             size_found;
    logic             size_changed;
    logic             intra_frame;
    modport source (output valid, frame_width, frame_height, size_found, size_changed,
                    intra_frame, input ready);
    modport sink   (input valid, frame_width, frame_height, size_found, size_changed,
                    intra_frame, output ready);
endinterface
`default_nettype wire

[rtl/core/mpeg4_vol_header_parser.sv]
// Top level: streaming MPEG-4 Part 2 VOL header parser, one byte per beat.
`default_nettype none
// Takes one byte of a sample per beat on stream and reports once per sample, on the beat
// that carries last_byte, on report. Byte-aligned start codes 00 00 01 are found; code B5
// parses the visual object, video object and video object layer headers (VBV fields and
// their markers included) and code B6 samples the VOP coding type. A bad prefix or code
// stops the parse until the sample ends; a failed VBV marker drops back to scanning on the
// next byte boundary. All eight bit steps of a byte are resolved in one pass of logic
// between the parse state register and the report register, so a byte is taken in every
// cycle while the report register is empty or being drained. The report gives width and
// height (0 if none), size_found, size_changed against the last reported size, and
// intra_frame.
module mpeg4_vol_header_parser
    import mvol_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mvol_byte_if.sink     stream,
    mvol_report_if.source report
);

    parse_state_t     st_reg, st_next, stepped;
    logic [DIM_W-1:0] rep_w_reg, rep_w_next, rep_h_reg, rep_h_next;
    logic             out_valid_reg, out_valid_next;
    logic [DIM_W-1:0] out_w_reg, out_w_next, out_h_reg, out_h_next;
    logic             out_found_reg, out_found_next;
    logic             out_chg_reg, out_chg_next;
    logic             out_key_reg, out_key_next;
    logic             in_acc, found, changed;

    // Field length of each phase; zero for scan, align and time increment.
    function automatic logic [LEFT_W-1:0] field_len(phase_t ph);
        logic [LEFT_W-1:0] len;
        len = '0;
        unique case (ph)
            PH_VO_ID, PH_SIG, PH_COLOR, PH_RAND, PH_OLID, PH_CTRL, PH_VBV,
            PH_VBV_MK1, PH_VBV_MK2, PH_VBV_MK3, PH_VBV_MK4, PH_VBV_LASTMK,
            PH_MK_RES, PH_MK_RATE, PH_FIXED, PH_MK_W, PH_MK_H, PH_MK_END:
                len = 5'd1;
            PH_VO_IDX:                      len = 5'd7;
            PH_VO_TYPE, PH_SIG_FMT, PH_OLVER, PH_ASPECT, PH_SHAPE_X: len = 5'd4;
            PH_COLOR_X, PH_VO_PFX, PH_VOL_PFX: len = 5'd24;
            PH_VO_CODE, PH_VOL_CODE, PH_OTI: len = 5'd8;
            PH_OLPRI, PH_CHROMA:            len = 5'd3;
            PH_PAR, PH_RES:                 len = 5'd16;
            PH_VBV_A, PH_VBV_B, PH_VBV_C, PH_VBV_E: len = 5'd15;
            PH_VBV_D:                       len = 5'd14;
            PH_SHAPE, PH_VOP:               len = 5'd2;
            PH_WIDTH, PH_HEIGHT:            len = 5'd13;
            default:                        len = '0;
        endcase
        return len;
    endfunction

    // ceil(log2(res)), at least 1.
    function automatic logic [LEFT_W-1:0] inc_bits(logic [RES_W-1:0] res);
        logic [RES_W-1:0]  r;
        logic [LEFT_W-1:0] n;
        r = res - 16'd1;
        n = 5'd1;
        for (int i = 1; i < RES_W; i++)
        begin
            if (r[i])
            begin
                n = LEFT_W'(i + 1);
            end
        end
        if (res <= 16'd1)
        begin
            n = 5'd1;
        end
        return n;
    endfunction

    // Enter a phase; an align of zero length falls straight through.
    function automatic parse_state_t enter(parse_state_t s, phase_t ph, logic [2:0] pos);
        parse_state_t      t;
        logic [LEFT_W-1:0] len;
        t = s;
        t.phase = ph;
        t.bits  = '0;
        t.left  = '0;
        if (ph == PH_ALIGN)
        begin
            len = {2'b00, pos};
        end
        else if (ph == PH_INC)
        begin
            len = inc_bits(s.res);
        end
        else
        begin
            len = field_len(ph);
        end
        if (ph != PH_SCAN)
        begin
            if (len != '0)
            begin
                t.left = len;
            end
            else if (s.version == 4'd1)
            begin
                t.phase = PH_VO_PFX;
                t.left  = field_len(PH_VO_PFX);
            end
            else
            begin
                t.phase = PH_SCAN;
            end
        end
        return t;
    endfunction

    // Close the current field with value v.
    function automatic parse_state_t finish(parse_state_t s, logic [2:0] pos);
        parse_state_t     t;
        phase_t           nx;
        logic [BUF_W-1:0] v;
        logic             stop;
        t    = s;
        v    = s.bits;
        nx   = PH_SCAN;
        stop = 1'b0;
        if (s.phase >= PH_VBV_A && s.phase <= PH_VBV_LASTMK)
        begin
            if (s.phase[0] == PH_VBV_A[0])
            begin
                nx = phase_t'(s.phase + 6'd1);
            end
            else if (v == '0)
            begin
                nx = PH_SCAN;
            end
            else
            begin
                nx = (s.phase == PH_VBV_LASTMK) ? PH_SHAPE : phase_t'(s.phase + 6'd1);
            end
        end
        else
        begin
            case (s.phase)
                PH_VO_ID:   nx = (v != '0) ? PH_VO_IDX : PH_VO_TYPE;
                PH_VO_IDX:  nx = PH_VO_TYPE;
                PH_VO_TYPE:
                begin
                    t.version = v[3:0];
                    nx = (v == 24'd1 || v == 24'd2) ? PH_SIG : PH_ALIGN;
                end
                PH_SIG:     nx = (v != '0) ? PH_SIG_FMT : PH_ALIGN;
                PH_SIG_FMT: nx = PH_COLOR;
                PH_COLOR:   nx = (v != '0) ? PH_COLOR_X : PH_ALIGN;
                PH_COLOR_X: nx = PH_ALIGN;
                PH_ALIGN:   nx = (s.version == 4'd1) ? PH_VO_PFX : PH_SCAN;
                PH_VO_PFX:
                begin
                    stop = (v != {16'd0, 8'd1});
                    nx   = PH_VO_CODE;
                end
                PH_VO_CODE:
                begin
                    stop = (v > {16'd0, VO_CODE_MAX});
                    nx   = PH_VOL_PFX;
                end
                PH_VOL_PFX:
                begin
                    stop = (v != {16'd0, 8'd1});
                    nx   = PH_VOL_CODE;
                end
                PH_VOL_CODE:
                begin
                    stop = (v < {16'd0, VOL_CODE_MIN}) || (v > {16'd0, VOL_CODE_MAX});
                    nx   = PH_RAND;
                end
                PH_RAND:    nx = PH_OTI;
                PH_OTI:
                begin
                    stop = (v == {16'd0, OTI_BAD});
                    nx   = PH_OLID;
                end
                PH_OLID:
                begin
                    t.version = 4'd0;
                    nx = (v != '0) ? PH_OLVER : PH_ASPECT;
                end
                PH_OLVER:
                begin
                    t.version = v[3:0];
                    nx = PH_OLPRI;
                end
                PH_OLPRI:   nx = PH_ASPECT;
                PH_ASPECT:  nx = (v == 24'd15) ? PH_PAR : PH_CTRL;
                PH_PAR:     nx = PH_CTRL;
                PH_CTRL:    nx = (v != '0) ? PH_CHROMA : PH_SHAPE;
                PH_CHROMA:  nx = PH_VBV;
                PH_VBV:     nx = (v != '0) ? PH_VBV_A : PH_SHAPE;
                PH_SHAPE:
                begin
                    t.shape = v[1:0];
                    nx = (v[1:0] == 2'd3 && s.version != 4'd1) ? PH_SHAPE_X : PH_MK_RES;
                end
                PH_SHAPE_X: nx = PH_MK_RES;
                PH_MK_RES:  nx = PH_RES;
                PH_RES:
                begin
                    t.res = v[RES_W-1:0];
                    nx = PH_MK_RATE;
                end
                PH_MK_RATE: nx = PH_FIXED;
                PH_FIXED:
                begin
                    if (v != '0)
                    begin
                        nx = PH_INC;
                    end
                    else
                    begin
                        nx = (s.shape == 2'd0) ? PH_MK_W : PH_SCAN;
                    end
                end
                PH_INC:     nx = (s.shape == 2'd0) ? PH_MK_W : PH_SCAN;
                PH_MK_W:    nx = PH_WIDTH;
                PH_WIDTH:
                begin
                    t.width = v[DIM_W-1:0];
                    nx = PH_MK_H;
                end
                PH_MK_H:    nx = PH_HEIGHT;
                PH_HEIGHT:
                begin
                    t.height = v[DIM_W-1:0];
                    nx = PH_MK_END;
                end
                PH_MK_END:  nx = PH_SCAN;
                PH_VOP:
                begin
                    t.key = (v == '0);
                    nx = PH_SCAN;
                end
                default:    nx = PH_SCAN;
            endcase
        end
        if (stop)
        begin
            t.stopped = 1'b1;
            t.phase   = PH_SCAN;
        end
        else
        begin
            t = enter(t, nx, pos);
        end
        return t;
    endfunction

    // One byte: either a scan step or up to eight bit steps of the header parse.
    function automatic parse_state_t step_byte(parse_state_t s, logic [BYTE_W-1:0] b);
        parse_state_t t;
        t = s;
        if (!s.stopped)
        begin
            if (s.phase == PH_SCAN)
            begin
                if (s.window == START_PREFIX)
                begin
                    t.window = '0;
                    if (b == CODE_VO)
                    begin
                        t = enter(t, PH_VO_ID, 3'd0);
                    end
                    else if (b == CODE_VOP)
                    begin
                        t = enter(t, PH_VOP, 3'd0);
                    end
                end
                else
                begin
                    t.window = {s.window[15:0], b};
                end
            end
            else
            begin
                for (int k = 0; k < BYTE_W; k++)
                begin
                    if (!t.stopped && t.phase != PH_SCAN)
                    begin
                        t.bits = {t.bits[BUF_W-2:0], b[BYTE_W-1-k]};
                        if (t.left != '0)
                        begin
                            t.left = t.left - 5'd1;
                        end
                        if (t.left == '0)
                        begin
                            t = finish(t, 3'(BYTE_W - 1 - k));
                        end
                    end
                end
            end
        end
        return t;
    endfunction

    // Take a byte whenever the report register is free or draining.
    assign stream.ready = !out_valid_reg || report.ready;
    assign in_acc       = stream.valid && stream.ready;

    always_comb
    begin
        stepped = step_byte(st_reg, stream.data_byte);
    end

    assign found   = (stepped.width != '0) && (stepped.height != '0);
    assign changed = found && ((stepped.width != rep_w_reg) || (stepped.height != rep_h_reg));

    // Next parse state: advance on every beat, clear at the end of a sample.
    always_comb
    begin
        st_next    = st_reg;
        rep_w_next = rep_w_reg;
        rep_h_next = rep_h_reg;
        if (in_acc)
        begin
            st_next = stepped;
            if (stream.last_byte)
            begin
                st_next       = '0;
                st_next.phase = PH_SCAN;
                if (changed)
                begin
                    rep_w_next = stepped.width;
                    rep_h_next = stepped.height;
                end
            end
        end
    end

    // Report register: load on the last byte, drop once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !report.ready;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        out_found_next = out_found_reg;
        out_chg_next   = out_chg_reg;
        out_key_next   = out_key_reg;
        if (in_acc && stream.last_byte)
        begin
            out_valid_next = 1'b1;
            out_w_next     = stepped.width;
            out_h_next     = stepped.height;
            out_found_next = found;
            out_chg_next   = changed;
            out_key_next   = stepped.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            rep_w_reg     <= '0;
            rep_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            rep_w_reg     <= rep_w_next;
            rep_h_reg     <= rep_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_w_reg     <= out_w_next;
        out_h_reg     <= out_h_next;
        out_found_reg <= out_found_next;
        out_chg_reg   <= out_chg_next;
        out_key_reg   <= out_key_next;
    end

    assign report.valid        = out_valid_reg;
    assign report.frame_width  = out_w_reg;
    assign report.frame_height = out_h_reg;
    assign report.size_found   = out_found_reg;
    assign report.size_changed = out_chg_reg;
    assign report.intra_frame  = out_key_reg;

`ifndef NO_ASSERTIONS
    a_stop_scan: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.stopped |-> st_reg.phase == PH_SCAN)
        else $error("stopped parse left in a field phase");

    a_field_len: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase != PH_SCAN |-> (st_reg.left != '0 && st_reg.left <= 5'd24))
        else $error("field length out of range");

    a_last_report: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && stream.last_byte |=> out_valid_reg)
        else $error("last byte gave no report");

    a_sample_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && stream.last_byte |=> st_reg.phase == PH_SCAN && !st_reg.stopped
            && st_reg.width == '0)
        else $error("sample state not cleared");
`endif

endmodule
`default_nettype wire

[verif/mvol_tb_pkg.sv]
// Package: shared widths and parse phase codes for the VOL header parser testbench.
`default_nettype none
package mvol_tb_pkg;

    localparam int unsigned TB_BYTE_W = 8;
    localparam int unsigned TB_DIM_W  = 13;

    typedef enum logic [5:0] {
        TP_SCAN       = 6'd0,
        TP_VO_ID      = 6'd1,
        TP_VO_IDX     = 6'd2,
        TP_VO_TYPE    = 6'd3,
        TP_SIG        = 6'd4,
        TP_SIG_FMT    = 6'd5,
        TP_COLOR      = 6'd6,
        TP_COLOR_X    = 6'd7,
        TP_ALIGN      = 6'd8,
        TP_VO_PFX     = 6'd9,
        TP_VO_CODE    = 6'd10,
        TP_VOL_PFX    = 6'd11,
        TP_VOL_CODE   = 6'd12,
        TP_RAND       = 6'd13,
        TP_OTI        = 6'd14,
        TP_OLID       = 6'd15,
        TP_OLVER      = 6'd16,
        TP_OLPRI      = 6'd17,
        TP_ASPECT     = 6'd18,
        TP_PAR        = 6'd19,
        TP_CTRL       = 6'd20,
        TP_CHROMA     = 6'd21,
        TP_VBV        = 6'd22,
        TP_VBV_A      = 6'd23,
        TP_VBV_LASTMK = 6'd32,
        TP_SHAPE      = 6'd33,
        TP_SHAPE_X    = 6'd34,
        TP_MK_RES     = 6'd35,
        TP_RES        = 6'd36,
        TP_MK_RATE    = 6'd37,
        TP_FIXED      = 6'd38,
        TP_INC        = 6'd39,
        TP_MK_W       = 6'd40,
        TP_WIDTH      = 6'd41,
        TP_MK_H       = 6'd42,
        TP_HEIGHT     = 6'd43,
        TP_MK_END     = 6'd44,
        TP_VOP        = 6'd45
    } tb_phase_t;

endpackage
`default_nettype wire

[verif/mpeg4_vol_header_parser_tb.sv]
// Testbench top: streams MPEG-4 header samples through the VOL parser and checks each report.
`default_nettype none
module mpeg4_vol_header_parser_tb
    import mvol_pkg::*, mvol_tb_pkg::*;
;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic        found;
        logic        changed;
        logic        key;
    } size_report_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    logic clk;
    logic rst_n;

    mvol_byte_if   stream ();
    mvol_report_if report ();

    mpeg4_vol_header_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream.sink),
        .report (report.source)
    );

    // ------------------------------------------------------------------
    // Shadow of the parser: per-sample header state plus the last size
    // that was reported. Bit buffer (32 bits) is wide enough for any field (up to 24).
    // ------------------------------------------------------------------
    logic [5:0]  sh_phase;
    logic [23:0] sh_window;
    logic [31:0] sh_bits;
    logic [5:0]  sh_left;
    logic [3:0]  sh_version;
    logic [1:0]  sh_shape;
    logic [15:0] sh_res;
    logic [12:0] sh_width;
    logic [12:0] sh_height;
    logic        sh_key;
    logic        sh_stopped;
    logic [12:0] rep_width;
    logic [12:0] rep_height;

    size_report_t expected_reports[$];
    byte_beat_t   pending_beats[$];

    int unsigned mismatches;
    int unsigned reports_seen;
    int unsigned cycle_count;
    int unsigned samples_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          recv_hold;
    int unsigned recv_hold_cycles;
    bit          send_pause;

    // Field length per phase; the VBV run alternates 15-bit values (14 for VBV_D) and markers.
    function automatic int unsigned field_width(input logic [5:0] ph);
        case (ph)
            TP_VO_ID, TP_SIG, TP_COLOR, TP_RAND, TP_OLID, TP_CTRL, TP_VBV,
            TP_MK_RES, TP_MK_RATE, TP_FIXED, TP_MK_W, TP_MK_H,
            TP_MK_END: return 1;
            TP_VO_IDX: return 7;
            TP_VO_TYPE, TP_SIG_FMT, TP_OLVER, TP_ASPECT, TP_SHAPE_X: return 4;
            TP_COLOR_X, TP_VO_PFX, TP_VOL_PFX: return 24;
            TP_VO_CODE, TP_VOL_CODE, TP_OTI: return 8;
            TP_OLPRI, TP_CHROMA: return 3;
            TP_PAR, TP_RES: return 16;
            TP_SHAPE, TP_VOP: return 2;
            TP_WIDTH, TP_HEIGHT: return 13;
            default:
            begin
                if (ph >= TP_VBV_A && ph <= TP_VBV_LASTMK)
                    return ((ph - TP_VBV_A) % 2 == 1) ? 1 :
                           (ph == 6'd29 ? 14 : 15);
                return 0;
            end
        endcase
    endfunction

    function automatic int unsigned inc_width();
        int unsigned n;
        n = 1;
        while (n < 16 && (32'd1 << n) < sh_res)
            n++;
        return n;
    endfunction

    task automatic clear_sample();
        sh_phase   = TP_SCAN;
        sh_window  = '0;
        sh_bits    = '0;
        sh_left    = '0;
        sh_version = '0;
        sh_shape   = '0;
        sh_res     = '0;
        sh_width   = '0;
        sh_height  = '0;
        sh_key     = 1'b0;
        sh_stopped = 1'b0;
    endtask

    // Enter a phase; fields of zero length fall through to the VO prefix (version 1) or to scan.
    task automatic enter_phase(input logic [5:0] ph, input int unsigned pos);
        int unsigned len;
        forever
        begin
            sh_phase = ph;
            sh_bits  = '0;
            sh_left  = '0;
            if (ph == TP_SCAN)
                return;
            if (ph == TP_ALIGN)
                len = pos;
            else if (ph == TP_INC)
                len = inc_width();
            else
                len = field_width(ph);
            if (len != 0)
            begin
                sh_left = 6'(len);
                return;
            end
            ph = (sh_version == 4'd1) ? TP_VO_PFX : TP_SCAN;
        end
    endtask

    task automatic field_done(input logic [31:0] v, input int unsigned pos);
        logic [5:0] ph;
        logic [5:0] nx;
        ph = sh_phase;
        nx = TP_SCAN;
        if (ph >= TP_VBV_A && ph <= TP_VBV_LASTMK)
        begin
            if ((ph - TP_VBV_A) % 2 == 0)
                nx = 6'(ph + 1);
            else if (v == 0)
                nx = TP_SCAN;
            else
                nx = (ph == TP_VBV_LASTMK) ? TP_SHAPE : 6'(ph + 1);
            enter_phase(nx, pos);
            return;
        end
        case (ph)
            TP_VO_ID:    nx = (v != 0) ? TP_VO_IDX : TP_VO_TYPE;
            TP_VO_IDX:   nx = TP_VO_TYPE;
            TP_VO_TYPE:
            begin
                sh_version = v[3:0];
                nx = (v == 1 || v == 2) ? TP_SIG : TP_ALIGN;
            end
            TP_SIG:      nx = (v != 0) ? TP_SIG_FMT : TP_ALIGN;
            TP_SIG_FMT:  nx = TP_COLOR;
            TP_COLOR:    nx = (v != 0) ? TP_COLOR_X : TP_ALIGN;
            TP_COLOR_X:  nx = TP_ALIGN;
            TP_ALIGN:    nx = (sh_version == 4'd1) ? TP_VO_PFX : TP_SCAN;
            TP_VO_PFX,
            TP_VOL_PFX:
            begin
                if (v != 1)
                begin
                    sh_stopped = 1'b1;
                    sh_phase   = TP_SCAN;
                    return;
                end
                nx = (ph == TP_VO_PFX) ? TP_VO_CODE : TP_VOL_CODE;
            end
            TP_VO_CODE:
            begin
                if (v > VO_CODE_MAX)
                begin
                    sh_stopped = 1'b1;
                    sh_phase   = TP_SCAN;
                    return;
                end
                nx = TP_VOL_PFX;
            end
            TP_VOL_CODE:
            begin
                if (v < VOL_CODE_MIN || v > VOL_CODE_MAX)
                begin
                    sh_stopped = 1'b1;
                    sh_phase   = TP_SCAN;
                    return;
                end
                nx = TP_RAND;
            end
            TP_RAND:     nx = TP_OTI;
            TP_OTI:
            begin
                if (v == OTI_BAD)
                begin
                    sh_stopped = 1'b1;
                    sh_phase   = TP_SCAN;
                    return;
                end
                nx = TP_OLID;
            end
            TP_OLID:
            begin
                sh_version = '0;
                nx = (v != 0) ? TP_OLVER : TP_ASPECT;
            end
            TP_OLVER:
            begin
                sh_version = v[3:0];
                nx = TP_OLPRI;
            end
            TP_OLPRI:    nx = TP_ASPECT;
            TP_ASPECT:   nx = (v == 15) ? TP_PAR : TP_CTRL;
            TP_PAR:      nx = TP_CTRL;
            TP_CTRL:     nx = (v != 0) ? TP_CHROMA : TP_SHAPE;
            TP_CHROMA:   nx = TP_VBV;
            TP_VBV:      nx = (v != 0) ? TP_VBV_A : TP_SHAPE;
            TP_SHAPE:
            begin
                sh_shape = v[1:0];
                nx = (sh_shape == 2'd3 && sh_version != 4'd1) ? TP_SHAPE_X : TP_MK_RES;
            end
            TP_SHAPE_X:  nx = TP_MK_RES;
            TP_MK_RES:   nx = TP_RES;
            TP_RES:
            begin
                sh_res = v[15:0];
                nx = TP_MK_RATE;
            end
            TP_MK_RATE:  nx = TP_FIXED;
            TP_FIXED:
            begin
                if (v != 0)
                    nx = TP_INC;
                else
                    nx = (sh_shape == 2'd0) ? TP_MK_W : TP_SCAN;
            end
            TP_INC:      nx = (sh_shape == 2'd0) ? TP_MK_W : TP_SCAN;
            TP_MK_W:     nx = TP_WIDTH;
            TP_WIDTH:
            begin
                sh_width = v[12:0];
                nx = TP_MK_H;
            end
            TP_MK_H:     nx = TP_HEIGHT;
            TP_HEIGHT:
            begin
                sh_height = v[12:0];
                nx = TP_MK_END;
            end
            TP_VOP:
            begin
                sh_key = (v == 0);
                nx = TP_SCAN;
            end
            default:     nx = TP_SCAN;
        endcase
        enter_phase(nx, pos);
    endtask

    // Advance the shadow parser by one accepted byte; queue a report on the last byte.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        size_report_t r;
        int           k;
        if (!sh_stopped)
        begin
            if (sh_phase == TP_SCAN)
            begin
                if (sh_window == START_PREFIX)
                begin
                    sh_window = '0;
                    if (b == CODE_VO)
                        enter_phase(TP_VO_ID, 0);
                    else if (b == CODE_VOP)
                        enter_phase(TP_VOP, 0);
                end
                else
                    sh_window = {sh_window[15:0], b};
            end
            else
            begin
                for (k = 0; k < 8; k++)
                begin
                    if (sh_stopped || sh_phase == TP_SCAN)
                        break;
                    sh_bits = {sh_bits[30:0], b[7-k]};
                    if (sh_left > 0)
                        sh_left--;
                    if (sh_left == 0)
                        field_done(sh_bits, 7 - k);
                end
            end
        end
        if (last)
        begin
            r.width   = sh_width;
            r.height  = sh_height;
            r.found   = (sh_width != 0 && sh_height != 0);
            r.changed = 1'b0;
            if (r.found && (sh_width != rep_width || sh_height != rep_height))
            begin
                r.changed  = 1'b1;
                rep_width  = sh_width;
                rep_height = sh_height;
            end
            r.key = sh_key;
            expected_reports.push_back(r);
            clear_sample();
        end
    endtask

    // ------------------------------------------------------------------
    // Sample builder: bit writer that packs header fields MSB first.
    // ------------------------------------------------------------------
    logic [7:0] build_bytes[$];
    logic [7:0] build_acc;
    int         build_cnt;

    task automatic put_bits(input logic [31:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
        begin
            build_acc = {build_acc[6:0], v[i]};
            build_cnt++;
            if (build_cnt == 8)
            begin
                build_bytes.push_back(build_acc);
                build_cnt = 0;
            end
        end
    endtask

    task automatic pad_byte();
        while (build_cnt != 0)
            put_bits($urandom_range(0, 1), 1);
    endtask

    // Well-formed VO + VOL header; knobs choose the branches and damage.
    task automatic put_vol_header(input logic [12:0] w, input logic [12:0] h,
                                  input logic [1:0] shape, input int damage);
        logic [15:0] res;
        int          i;
        int          bad_mk;
        put_bits(32'h000001b5, 32);
        put_bits($urandom_range(0, 1), 1);
        if (build_cnt == 1 && build_acc[0])
            put_bits($urandom, 7);
        put_bits(1, 4);
        if ($urandom_range(0, 1))
        begin
            put_bits(1, 1);
            put_bits($urandom, 4);
            put_bits($urandom_range(0, 1), 1);
            if (build_acc[0])
                put_bits($urandom, 24);
        end
        else
            put_bits(0, 1);
        pad_byte();
        put_bits(damage == 1 ? 32'h000002 : 32'h000001, 24);
        put_bits(damage == 2 ? $urandom_range(8'h20, 8'hff) : $urandom_range(0, 8'h1f), 8);
        put_bits(32'h000001, 24);
        put_bits(damage == 3 ? ($urandom_range(0, 1) ? $urandom_range(0, 8'h1f) :
                 $urandom_range(8'h30, 8'hff)) : $urandom_range(8'h20, 8'h2f), 8);
        put_bits($urandom_range(0, 1), 1);
        put_bits(damage == 4 ? OTI_BAD : 8'h01, 8);
        if ($urandom_range(0, 1))
        begin
            put_bits(1, 1);
            put_bits($urandom_range(0, 3) == 0 ? 1 : $urandom, 4);
            put_bits($urandom, 3);
        end
        else
            put_bits(0, 1);
        if ($urandom_range(0, 2) == 0)
        begin
            put_bits(15, 4);
            put_bits($urandom, 16);
        end
        else
            put_bits($urandom_range(0, 14), 4);
        if ($urandom_range(0, 1))
        begin
            put_bits(1, 1);
            put_bits($urandom, 3);
            if ($urandom_range(0, 1))
            begin
                bad_mk = (damage == 5) ? $urandom_range(0, 4) : -1;
                put_bits(1, 1);
                for (i = 0; i < 5; i++)
                begin
                    put_bits($urandom, i == 3 ? 14 : 15);
                    put_bits(i == bad_mk ? 0 : 1, 1);
                end
            end
            else
                put_bits(0, 1);
        end
        else
            put_bits(0, 1);
        put_bits(shape, 2);
        if (shape == 2'd3)
            put_bits($urandom_range(0, 1) ? 0 : $urandom, 4);
        put_bits($urandom_range(0, 1), 1);
        case ($urandom_range(0, 3))
            0: res = 16'd0;
            1: res = 16'hffff;
            default: res = 16'($urandom_range(1, 300));
        endcase
        put_bits(res, 16);
        put_bits($urandom_range(0, 1), 1);
        if ($urandom_range(0, 1))
        begin
            put_bits(1, 1);
            put_bits($urandom, 16);
        end
        else
            put_bits(0, 1);
        put_bits($urandom_range(0, 1), 1);
        put_bits(w, 13);
        put_bits($urandom_range(0, 1), 1);
        put_bits(h, 13);
        put_bits($urandom_range(0, 1), 1);
        pad_byte();
    endtask

    // Push the sample's bytes, optionally cut short, with last_byte on the final one.
    task automatic queue_sample(input int cut);
        byte_beat_t bb;
        int         n;
        int         i;
        pad_byte();
        if (build_bytes.size() == 0)
            build_bytes.push_back(8'($urandom));
        n = build_bytes.size();
        if (cut > 0 && cut < n)
            n = cut;
        for (i = 0; i < n; i++)
        begin
            bb.data = build_bytes[i];
            bb.last = (i == n - 1);
            pending_beats.push_back(bb);
        end
        build_bytes.delete();
        build_cnt = 0;
        samples_sent++;
    endtask

    task automatic put_vop(input logic [1:0] ctype);
        put_bits(32'h000001b6, 32);
        put_bits(ctype, 2);
        put_bits($urandom, 6);
    endtask

    task automatic put_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            put_bits($urandom_range(0, 3) == 0 ? 0 : $urandom, 8);
    endtask

    // Random sample: mostly well-formed headers and VOPs around noise.
    task automatic random_sample();
        int          kind;
        logic [12:0] w;
        logic [12:0] h;
        kind = $urandom_range(0, 99);
        w = 13'($urandom_range(0, 9) == 0 ? 13'h1fff : $urandom_range(0, 3) == 0 ?
            $urandom_range(0, 1) * 13'd176 : $urandom_range(0, 8191));
        h = 13'($urandom_range(0, 9) == 0 ? 13'd0 : $urandom_range(0, 8191));
        if ($urandom_range(0, 2) == 0)
            put_noise($urandom_range(0, 3));
        if (kind < 70)
        begin
            put_vol_header(w, h, $urandom_range(0, 3) == 0 ? 2'($urandom) : 2'd0,
                           $urandom_range(0, 4) == 0 ? $urandom_range(1, 5) : 0);
            if ($urandom_range(0, 1))
                put_vop(2'($urandom));
            queue_sample($urandom_range(0, 5) == 0 ? $urandom_range(1, 30) : 0);
        end
        else if (kind < 85)
        begin
            put_vop(2'($urandom));
            put_noise($urandom_range(0, 2));
            queue_sample(0);
        end
        else
        begin
            put_noise($urandom_range(1, 12));
            queue_sample(0);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and cycle watchdog.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: hold the beat until accepted, then advance or idle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream.valid     <= 1'b0;
            stream.data_byte <= '0;
            stream.last_byte <= 1'b0;
        end
        else if (!stream.valid || stream.ready)
        begin
            if (stream.valid)
                parse_byte(stream.data_byte, stream.last_byte);
            if (pending_beats.size() != 0 && !send_pause &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                stream.valid     <= 1'b1;
                stream.data_byte <= pending_beats[0].data;
                stream.last_byte <= pending_beats[0].last;
                void'(pending_beats.pop_front());
            end
            else
                stream.valid <= 1'b0;
        end
    end

    // Count the cycles of a long receiver hold-off while it is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            recv_hold_cycles <= 0;
        else if (recv_hold)
            recv_hold_cycles <= recv_hold_cycles + 1;
        else
            recv_hold_cycles <= 0;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted report with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        size_report_t want;
        size_report_t got;
        if (!rst_n)
            report.ready <= 1'b0;
        else
        begin
            if (report.valid && report.ready)
            begin
                got = '{report.frame_width, report.frame_height, report.size_found,
                        report.size_changed, report.intra_frame};
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected report: %p", got);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Report %0d mismatch: expected %p, got %p",
                                     reports_seen, want, got);
                    end
                end
            end
            if (recv_hold)
                report.ready <= 1'b0;
            else
                report.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Build random samples for one phase with the given idle and stall mix and wait for them to drain.
    task automatic run_phase(input int idle, input int stall, input int n_samples);
        int i;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (i = 0; i < n_samples; i++)
            random_sample();
        wait (pending_beats.size() == 0 && !stream.valid && expected_reports.size() == 0);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        int i;
        mismatches     = 0;
        reports_seen   = 0;
        cycle_count    = 0;
        samples_sent   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b0;
        send_pause     = 1'b0;
        build_cnt      = 0;
        build_acc      = '0;
        rep_width      = '0;
        rep_height     = '0;
        clear_sample();
        stream.valid     = 1'b0;
        stream.data_byte = '0;
        stream.last_byte = 1'b0;
        report.ready     = 1'b0;

        // Directed: extreme sizes, repeated size, zero size, VOP key and non-key,
        // each bad code, a failed VBV marker when the VBV fields are drawn, shape not rectangular, truncation.
        put_vol_header(13'h1fff, 13'h1fff, 2'd0, 0); put_vop(2'd0); queue_sample(0);
        put_vol_header(13'h1fff, 13'h1fff, 2'd0, 0); put_vop(2'd3); queue_sample(0);
        put_vol_header(13'd1, 13'd1, 2'd0, 0); queue_sample(0);
        put_vol_header(13'd0, 13'd64, 2'd0, 0); queue_sample(0);
        for (i = 1; i <= 5; i++)
        begin
            put_vol_header(13'd320, 13'd240, 2'd0, i);
            queue_sample(0);
        end
        put_vol_header(13'd320, 13'd240, 2'd3, 0); queue_sample(0);
        put_vol_header(13'd640, 13'd480, 2'd0, 0); queue_sample(20);
        put_bits(32'h00000001, 32); put_bits(32'hb6ff00ff, 32); queue_sample(0);
        put_bits(32'hffffffff, 32); queue_sample(1);
        put_bits(32'h00000000, 8); queue_sample(1);

        wait (pending_beats.size() == 0 && !stream.valid && expected_reports.size() == 0);
        repeat (3) @(posedge clk);

        run_phase(0, 0, 1);
        run_phase(72, 0, 1);
        run_phase(0, 72, 1);
        run_phase(72, 72, 1);
        run_phase(9, 9, 1);

        // Long receiver hold-off while bytes keep coming: the parser must back up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (i = 0; i < 3; i++)
            random_sample();
        @(posedge clk);
        recv_hold <= 1'b1;
        wait (recv_hold_cycles >= 300);
        recv_hold <= 1'b0;
        wait (pending_beats.size() == 0 && !stream.valid && expected_reports.size() == 0);

        // Sender pause until every report is in, then resume.
        send_pause = 1'b1;
        random_sample();
        wait (expected_reports.size() == 0);
        repeat (20) @(posedge clk);
        send_pause = 1'b0;
        run_phase(30, 30, 1);

        wait (expected_reports.size() == 0);
        repeat (20) @(posedge clk);

        $display("Sent %0d samples, checked %0d reports across idle and stall mixes",
                 samples_sent, reports_seen);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
